FILE: rtl/core/yawpid_pkg.sv
package yawpid_pkg;

    localparam int ERR_W    = 18;
    localparam int YAW_W    = 17;
    localparam int BASE_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int INTEG_W  = 26;
    localparam int DY100_W  = 25;
    localparam int PK_W     = ERR_W + GAIN_W + 1;
    localparam int IK_W     = INTEG_W + GAIN_W + 1;
    localparam int DK_W     = DY100_W + GAIN_W + 1;
    localparam int P_W      = PK_W - 8;
    localparam int D_W      = DK_W - 8;
    localparam int IV_W     = IK_W - 8;
    localparam int DIVIN_W  = 31;
    localparam int RECIP_W  = 32;
    localparam int QPROD_W  = DIVIN_W + RECIP_W;
    localparam int RECIP_SH = 38;
    localparam int Q_W      = QPROD_W - RECIP_SH;
    localparam int SUM_W    = 36;
    localparam int CORR_W   = 17;
    localparam int MIX_W    = 19;
    localparam int ADDR_W   = 3;

    localparam logic [2:0] REG_KP        = 3'd0;
    localparam logic [2:0] REG_KI        = 3'd1;
    localparam logic [2:0] REG_KD        = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT = 3'd3;
    localparam logic [2:0] REG_DRV_LIMIT = 3'd4;

    localparam logic [15:0] INT_LIMIT_RST = 16'd25600;
    localparam logic [15:0] DRV_LIMIT_RST = 16'd65280;

    localparam logic signed [18:0] HALF_TURN = 19'sd46080;
    localparam logic signed [18:0] FULL_TURN = 19'sd92160;
    localparam logic signed [MIX_W-1:0] WHEEL_MAX = 19'sd65280;
    localparam logic [22:0] DT_INV = 23'd100;
    localparam logic [RECIP_W-1:0] RECIP_100 = 32'd2748779070;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] integral_limit;
        logic [GAIN_W-1:0] drive_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DY100_W-1:0] dyaw100;
        logic signed [INTEG_W-1:0] integ;
        logic [BASE_W-1:0]         base;
        logic                      dir;
    } front_t;

    typedef struct packed {
        logic signed [P_W-1:0] p;
        logic signed [D_W-1:0] d;
        logic                  i_neg;
        logic [Q_W-1:0]        i_mag;
        logic [BASE_W-1:0]     base;
        logic                  dir;
    } terms_t;

endpackage

FILE: rtl/core/yawpid_front.sv
module yawpid_front
    import yawpid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [ERR_W-1:0]  yaw_error,
    input  logic signed [YAW_W-1:0]  meas_yaw,
    input  logic [BASE_W-1:0]        base_level,
    input  logic                     direction,
    input  logic                     clear_integral,
    input  cfg_t                     cfg,
    output front_t                   stage_out,
    output logic                     stage_valid
);

    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [YAW_W-1:0]   prev_yaw_reg;
    front_t                    stage_reg;
    logic                      valid_reg;

    logic signed [INTEG_W-1:0] integ_base;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W:0]   ilim;
    logic [22:0]               ilim_u;
    logic signed [18:0]        dyaw_raw;
    logic signed [18:0]        dyaw_wrap;
    logic signed [ERR_W-1:0]   dyaw;
    logic signed [DY100_W-1:0] dyaw100;

    always_comb begin
        integ_base = clear_integral ? '0 : integ_reg;
        isum       = (INTEG_W+1)'(integ_base) + (INTEG_W+1)'(yaw_error);
        ilim_u     = 23'(cfg.integral_limit) * DT_INV;
        ilim       = $signed({{(INTEG_W-22){1'b0}}, ilim_u});
        if (isum > ilim) begin
            integ_next = INTEG_W'(ilim);
        end else if (isum < -ilim) begin
            integ_next = INTEG_W'(-ilim);
        end else begin
            integ_next = INTEG_W'(isum);
        end
        dyaw_raw = 19'(meas_yaw) - 19'(prev_yaw_reg);
        if (dyaw_raw > HALF_TURN) begin
            dyaw_wrap = dyaw_raw - FULL_TURN;
        end else if (dyaw_raw < -HALF_TURN) begin
            dyaw_wrap = dyaw_raw + FULL_TURN;
        end else begin
            dyaw_wrap = dyaw_raw;
        end
        dyaw    = ERR_W'(dyaw_wrap);
        dyaw100 = DY100_W'(dyaw) * 25'sd100;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_yaw_reg <= '0;
            valid_reg    <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                integ_reg    <= integ_next;
                prev_yaw_reg <= meas_yaw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            stage_reg.err     <= yaw_error;
            stage_reg.dyaw100 <= dyaw100;
            stage_reg.integ   <= integ_next;
            stage_reg.base    <= base_level;
            stage_reg.dir     <= direction;
        end
    end

    assign stage_out   = stage_reg;
    assign stage_valid = valid_reg;

endmodule

FILE: rtl/core/yawpid_mult.sv
module yawpid_mult
    import yawpid_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  front_t stage_in,
    input  cfg_t   cfg,
    output terms_t stage_out,
    output logic   stage_valid
);

    logic signed [PK_W-1:0] pk, pk_reg;
    logic signed [IK_W-1:0] ik, ik_reg;
    logic signed [DK_W-1:0] dk, dk_reg;
    logic [BASE_W-1:0]      base_reg;
    logic                   dir_reg;
    logic                   valid1_reg;

    logic signed [IV_W-1:0] iv;
    logic [IV_W-1:0]        iu;
    logic [QPROD_W-1:0]     qprod;
    terms_t                 terms_reg;
    logic                   valid2_reg;

    assign pk = PK_W'($signed({1'b0, cfg.kp})) * PK_W'(stage_in.err);
    assign ik = IK_W'($signed({1'b0, cfg.ki})) * IK_W'(stage_in.integ);
    assign dk = DK_W'($signed({1'b0, cfg.kd})) * DK_W'(stage_in.dyaw100);

    always_ff @(posedge aclk) begin
        if (en) begin
            pk_reg   <= pk;
            ik_reg   <= ik;
            dk_reg   <= dk;
            base_reg <= stage_in.base;
            dir_reg  <= stage_in.dir;
        end
    end

    // Floor division by 100 of the integral product: the negative case uses
    // floor(v / 100) = -(floor((-v - 1) / 100)) - 1, i.e. the one's complement.
    always_comb begin
        iv    = ik_reg[IK_W-1:8];
        iu    = iv[IV_W-1] ? ~iv : iv;
        qprod = QPROD_W'(iu[DIVIN_W-1:0]) * QPROD_W'(RECIP_100);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg.p     <= pk_reg[PK_W-1:8];
            terms_reg.d     <= dk_reg[DK_W-1:8];
            terms_reg.i_neg <= iv[IV_W-1];
            terms_reg.i_mag <= qprod[QPROD_W-1:RECIP_SH];
            terms_reg.base  <= base_reg;
            terms_reg.dir   <= dir_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    assign stage_out   = terms_reg;
    assign stage_valid = valid2_reg;

endmodule

FILE: rtl/core/yawpid_mix.sv
module yawpid_mix
    import yawpid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  terms_t                   stage_in,
    input  cfg_t                     cfg,
    output logic [BASE_W-1:0]        left_level,
    output logic [BASE_W-1:0]        right_level,
    output logic                     wheel_direction,
    output logic signed [CORR_W-1:0] correction,
    output logic                     out_valid
);

    logic signed [Q_W:0]       i_term;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   dlim;
    logic signed [CORR_W-1:0]  corr;
    logic signed [CORR_W-1:0]  corr_reg;
    logic [BASE_W-1:0]         base_reg;
    logic                      dir_reg;
    logic                      valid1_reg;

    logic signed [MIX_W-1:0]   base_q;
    logic signed [MIX_W-1:0]   lf, rf;
    logic [BASE_W-1:0]         left_next, right_next;
    logic [BASE_W-1:0]         left_reg, right_reg;
    logic                      wdir_reg;
    logic signed [CORR_W-1:0]  corr_out_reg;
    logic                      valid2_reg;

    function automatic logic [BASE_W-1:0] wheel_sat(input logic signed [MIX_W-1:0] v);
        logic signed [MIX_W-1:0] c;
        if (v > WHEEL_MAX) begin
            c = WHEEL_MAX;
        end else if (v < 0) begin
            c = '0;
        end else begin
            c = v;
        end
        return c[15:8];
    endfunction

    always_comb begin
        i_term = stage_in.i_neg ? ~$signed({1'b0, stage_in.i_mag})
                                : $signed({1'b0, stage_in.i_mag});
        sum    = SUM_W'(stage_in.p) + SUM_W'(i_term) - SUM_W'(stage_in.d);
        dlim   = $signed({{(SUM_W-GAIN_W){1'b0}}, cfg.drive_limit});
        if (sum > dlim) begin
            corr = CORR_W'(dlim);
        end else if (sum < -dlim) begin
            corr = CORR_W'(-dlim);
        end else begin
            corr = CORR_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corr_reg <= corr;
            base_reg <= stage_in.base;
            dir_reg  <= stage_in.dir;
        end
    end

    always_comb begin
        base_q = $signed({{(MIX_W-BASE_W-8){1'b0}}, base_reg, 8'd0});
        if (!dir_reg) begin
            lf = base_q + MIX_W'(corr_reg);
            rf = base_q - MIX_W'(corr_reg);
        end else begin
            lf = base_q - MIX_W'(corr_reg);
            rf = base_q + MIX_W'(corr_reg);
        end
        left_next  = wheel_sat(lf);
        right_next = wheel_sat(rf);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            wdir_reg     <= dir_reg;
            corr_out_reg <= corr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    assign left_level      = left_reg;
    assign right_level     = right_reg;
    assign wheel_direction = wdir_reg;
    assign correction      = corr_out_reg;
    assign out_valid       = valid2_reg;

endmodule

FILE: rtl/core/yaw_pid_differential_drive.sv
// Yaw PID controller with differential-drive mixing. Each input word carries
// a Q10.8 heading error, the measured yaw and a base wheel level; the block
// keeps a clamped error integral and the previous yaw, and returns one result
// word with the left and right wheel levels, the direction and the clamped
// Q9.8 correction. One word is accepted every cycle unless the pipeline is
// held, and each word passes five register stages: the integral and
// yaw-change update, the gain multipliers, the reciprocal multiplier that
// divides the integral term by 100, the sum and clamp, and the wheel mixing.
// The whole pipeline holds while the result register is full and not taken.
// Gains and limits must be written through the configuration port only
// while no word is in flight; the block itself does not enforce this.
module yaw_pid_differential_drive
    import yawpid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [GAIN_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // yaw_error [17:0], measured yaw [34:18], base level [42:35], zero [47:43]
    input  logic [47:0]         s_tdata,
    // direction [0], clear_integral [1]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // left level [7:0], right level [15:8], correction [32:16], zero [39:33]
    output logic [39:0]         m_tdata,
    // wheel_direction [0]
    output logic [0:0]          m_tuser
);

    cfg_t   cfg_reg;
    logic   en;
    front_t front_stage;
    logic   front_valid;
    terms_t terms_stage;
    logic   terms_valid;

    logic [BASE_W-1:0]        left_level, right_level;
    logic                     wheel_direction;
    logic signed [CORR_W-1:0] correction;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp             <= '0;
            cfg_reg.ki             <= '0;
            cfg_reg.kd             <= '0;
            cfg_reg.integral_limit <= INT_LIMIT_RST;
            cfg_reg.drive_limit    <= DRV_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KP:        cfg_reg.kp             <= cfg_wdata;
                REG_KI:        cfg_reg.ki             <= cfg_wdata;
                REG_KD:        cfg_reg.kd             <= cfg_wdata;
                REG_INT_LIMIT: cfg_reg.integral_limit <= cfg_wdata;
                REG_DRV_LIMIT: cfg_reg.drive_limit    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    yawpid_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_tvalid),
        .yaw_error      ($signed(s_tdata[17:0])),
        .meas_yaw       ($signed(s_tdata[34:18])),
        .base_level     (s_tdata[42:35]),
        .direction      (s_tuser[0]),
        .clear_integral (s_tuser[1]),
        .cfg            (cfg_reg),
        .stage_out      (front_stage),
        .stage_valid    (front_valid)
    );

    yawpid_mult u_mult (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (front_valid),
        .stage_in    (front_stage),
        .cfg         (cfg_reg),
        .stage_out   (terms_stage),
        .stage_valid (terms_valid)
    );

    yawpid_mix u_mix (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (terms_valid),
        .stage_in        (terms_stage),
        .cfg             (cfg_reg),
        .left_level      (left_level),
        .right_level     (right_level),
        .wheel_direction (wheel_direction),
        .correction      (correction),
        .out_valid       (m_tvalid)
    );

    assign m_tdata = {7'd0, correction, right_level, left_level};
    assign m_tuser = wheel_direction;

endmodule
